// File: sv/cac_pkg.sv
// ----------------------------------------------------------------------------
// Cell anisotropy classifier package
// Shared widths, codes and state encodings for the classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

package cac_pkg;

  localparam int INDEX_BITS  = 20;
  localparam int WEIGHT_W    = 32;
  localparam int CNT_W       = 7;
  localparam int SUM_W       = 39;
  localparam int PROD_W      = WEIGHT_W + CNT_W;
  localparam int RATIO_W     = 24;
  localparam int FRAC_W      = 16;
  localparam int THR_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int STEP_W      = 5;

  localparam logic [CNT_W-1:0]  MAX_DEGREE  = CNT_W'(64);
  localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(4);
  localparam logic [STEP_W-1:0] DIV_STEPS   = STEP_W'(RATIO_W);

  localparam logic [CNT_W-1:0] CNT_2D_INNER = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_2D_EDGE  = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_3D_INNER = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_3D_EDGE  = CNT_W'(5);

  typedef enum logic [1:0] {
    MODE_RATIO = 2'd0,
    MODE_NONE  = 2'd1,
    MODE_2D    = 2'd2,
    MODE_3D    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CLS_ISO   = 2'd0,
    CLS_ANISO = 2'd1,
    CLS_NONE  = 2'd2
  } class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_ACC,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// File: sv/cac_in_if.sv
// ----------------------------------------------------------------------------
// Classifier input channel
// Valid/ready channel carrying one adjacency entry per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_in_if;
  import cac_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [INDEX_BITS-1:0]    cell_index;
  logic [INDEX_BITS-1:0]    neighbour_index;
  logic [WEIGHT_W-1:0]      face_weight;
  logic                     on_boundary;
  logic                     last_entry;

  modport source (
    output valid, cell_index, neighbour_index, face_weight, on_boundary, last_entry,
    input  ready
  );

  modport sink (
    input  valid, cell_index, neighbour_index, face_weight, on_boundary, last_entry,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cac_out_if.sv
// ----------------------------------------------------------------------------
// Classifier result channel
// Valid/ready channel carrying one cell classification per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_out_if;
  import cac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] result_cell;
  class_t                cell_class;
  logic [WEIGHT_W-1:0]   peak_weight;
  logic [RATIO_W-1:0]    peak_to_mean;
  logic [CNT_W-1:0]      neighbour_count;

  modport source (
    output valid, result_cell, cell_class, peak_weight, peak_to_mean, neighbour_count,
    input  ready
  );

  modport sink (
    input  valid, result_cell, cell_class, peak_weight, peak_to_mean, neighbour_count,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cac_cfg_if.sv
// ----------------------------------------------------------------------------
// Classifier configuration channel
// Valid/ready register write channel with register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cac_cfg_if;
  import cac_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/cell_anisotropy_classifier_core.sv
// ----------------------------------------------------------------------------
// Cell anisotropy classifier core
// Accumulates a cell's adjacency entries and, on its last entry, classifies the
// cell and computes its peak-to-mean ratio with a shared bit-serial divider.
// ----------------------------------------------------------------------------
// An entry that is not marked last is taken while the core accumulates, so the
// entries of a cell stream in at one word per clock. After the last entry of a
// cell, no word is taken until the core has registered it, formed the peak
// times count product, made one range check, run 24 steps of the restoring
// divider, which produces one quotient bit per cycle, and loaded the result
// register. A zero count, zero sum or saturated ratio skips the divider
// steps. A finished result waits in its own output register, so the next
// cell's entries are accepted while it is still pending; the load cycle
// itself waits for as long as the word before it has not been taken.
`default_nettype none

module cell_anisotropy_classifier_core (
  input  wire logic clk,
  input  wire logic rst_n,
  cac_in_if.sink    in_port,
  cac_out_if.source out_port,
  cac_cfg_if.sink   cfg_port
);
  import cac_pkg::*;

  state_t                state_r, state_nxt;
  mode_t                 mode_r;
  logic [THR_W-1:0]      thr_r;

  logic [WEIGHT_W-1:0]   min_r, min_nxt;
  logic [WEIGHT_W-1:0]   max_r, max_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] cell_r;
  logic                  bnd_r;

  logic [PROD_W-1:0]     prod_r;
  logic [SUM_W-1:0]      rem_r;
  logic [RATIO_W-1:0]    quot_r;
  logic [STEP_W-1:0]     step_r;

  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_cell_r;
  class_t                out_class_r, class_nxt;
  logic [WEIGHT_W-1:0]   out_peak_r;
  logic [RATIO_W-1:0]    out_ratio_r;
  logic [CNT_W-1:0]      out_cnt_r;

  logic                  in_acc;
  logic                  nonself;
  logic [SUM_W:0]        sum_wide;
  logic                  skip_div;
  logic                  div_ovf;
  logic [SUM_W:0]        rem_shift;
  logic                  div_ge;
  logic [SUM_W:0]        rem_sub;
  logic                  load_out;
  logic [WEIGHT_W+THR_W-1:0] thr_min;
  logic                  ratio_ok;
  logic                  fits_2d, fits_3d;

  // Accumulation of one entry.
  assign in_acc   = in_port.valid && in_port.ready;
  assign nonself  = in_port.cell_index != in_port.neighbour_index;
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(in_port.face_weight);

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    cnt_nxt = cnt_r;
    if (nonself) begin
      if (in_port.face_weight > max_r) max_nxt = in_port.face_weight;
      if (in_port.face_weight < min_r) min_nxt = in_port.face_weight;
      if (cnt_r < MAX_DEGREE) cnt_nxt = cnt_r + CNT_W'(1);
    end
    sum_nxt = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
  end

  // Divider range check and one restoring step.
  assign skip_div  = (cnt_r == '0) || (sum_r == '0);
  assign div_ovf   = SUM_W'(prod_r[PROD_W-1:PROD_W-31]) >= sum_r;
  assign rem_shift = {rem_r, quot_r[RATIO_W-1]};
  assign div_ge    = rem_shift >= {1'b0, sum_r};
  assign rem_sub   = rem_shift - {1'b0, sum_r};

  // Classification.
  assign thr_min  = (WEIGHT_W+THR_W)'(thr_r) * (WEIGHT_W+THR_W)'(min_r);
  assign ratio_ok = (max_r != '0) && (thr_min <= (WEIGHT_W+THR_W)'(max_r));
  assign fits_2d  = (cnt_r == CNT_2D_INNER) || (bnd_r && cnt_r == CNT_2D_EDGE);
  assign fits_3d  = (cnt_r == CNT_3D_INNER) || (bnd_r && cnt_r == CNT_3D_EDGE);

  always_comb begin
    unique case (mode_r)
      MODE_RATIO: class_nxt = ratio_ok ? CLS_ANISO : CLS_ISO;
      MODE_NONE:  class_nxt = CLS_NONE;
      MODE_2D:    class_nxt = (ratio_ok && fits_2d) ? CLS_ANISO : CLS_ISO;
      MODE_3D:    class_nxt = (ratio_ok && fits_3d) ? CLS_ANISO : CLS_ISO;
      default:    class_nxt = CLS_ISO;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_ACC:   if (in_acc && in_port.last_entry) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = (skip_div || div_ovf) ? S_DONE : S_DIV;
      S_DIV:   if (step_r == STEP_W'(1)) state_nxt = S_DONE;
      S_DONE:  if (!out_valid_r || out_port.ready) state_nxt = S_ACC;
      default: state_nxt = S_ACC;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_port.ready = (state_r == S_ACC);
    load_out      = (state_r == S_DONE) && (!out_valid_r || out_port.ready);
    cfg_port.ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RATIO;
      thr_r  <= THR_RESET;
    end else if (cfg_port.valid && cfg_port.ready) begin
      unique case (cfg_port.index)
        REG_MODE:      mode_r <= mode_t'(cfg_port.data[1:0]);
        REG_THRESHOLD: thr_r  <= cfg_port.data[THR_W-1:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || load_out) begin
      min_r <= {WEIGHT_W{1'b1}};
      max_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end else if (in_acc) begin
      min_r <= min_nxt;
      max_r <= max_nxt;
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_r <= in_port.cell_index;
      bnd_r  <= in_port.on_boundary;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(max_r) * PROD_W'(cnt_r);
    end
    if (state_r == S_CHECK) begin
      rem_r  <= SUM_W'(prod_r[PROD_W-1:PROD_W-31]);
      step_r <= DIV_STEPS;
      if (skip_div) begin
        quot_r <= '0;
      end else if (div_ovf) begin
        quot_r <= {RATIO_W{1'b1}};
      end else begin
        quot_r <= {prod_r[7:0], {FRAC_W{1'b0}}};
      end
    end
    if (state_r == S_DIV) begin
      rem_r  <= div_ge ? rem_sub[SUM_W-1:0] : rem_shift[SUM_W-1:0];
      quot_r <= {quot_r[RATIO_W-2:0], div_ge};
      step_r <= step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_port.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_cell_r  <= cell_r;
      out_class_r <= class_nxt;
      out_peak_r  <= max_r;
      out_ratio_r <= quot_r;
      out_cnt_r   <= cnt_r;
    end
  end

  assign out_port.valid           = out_valid_r;
  assign out_port.result_cell     = out_cell_r;
  assign out_port.cell_class      = out_class_r;
  assign out_port.peak_weight     = out_peak_r;
  assign out_port.peak_to_mean    = out_ratio_r;
  assign out_port.neighbour_count = out_cnt_r;

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ACC) |-> !in_port.ready)
    else $error("input ready while a cell is being finished");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_DEGREE)
    else $error("neighbour count above degree bound");

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < sum_r))
    else $error("divider remainder not below divisor");

  a_clear_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (cnt_r == '0 && sum_r == '0 && max_r == '0 && out_valid_r))
    else $error("accumulators not cleared after result load");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_r != '0 && step_r <= DIV_STEPS))
    else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire
